// ----- hw/rtl/sed_pkg.sv -----
// Shared constants, codes and types of the speed event detector.
package sed_pkg;

  localparam int SED_LOOKAHEAD  = 3;
  localparam int SED_SPEED_BITS = 16;
  localparam int SED_FRAME_BITS = 16;

  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_IDX_BITS   = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE         = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ENTER_THR    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EXIT_THR     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_TRAIL    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMPACT_OFFS  = 3'd4;

  localparam logic [CFG_DATA_BITS-1:0] MIN_TRAIL_RST = 16'd1;

  typedef enum logic {
    MODE_TRAIL  = 1'b0,
    MODE_IMPACT = 1'b1
  } mode_t;

  typedef enum logic {
    EV_TRAIL  = 1'b0,
    EV_IMPACT = 1'b1
  } ev_kind_t;

endpackage

// ----- hw/rtl/sed_if.sv -----
// Valid/ready channel interfaces for speed samples and detected events.
interface sed_in_if #(
  parameter int SPEED_BITS = sed_pkg::SED_SPEED_BITS
);
  logic                  valid;
  logic                  ready;
  logic [SPEED_BITS-1:0] speed;
  logic                  last_sample;

  modport source (output valid, output speed, output last_sample, input ready);
  modport sink   (input valid, input speed, input last_sample, output ready);
endinterface

interface sed_out_if #(
  parameter int FRAME_BITS = sed_pkg::SED_FRAME_BITS
);
  logic                  valid;
  logic                  ready;
  logic                  event_kind;
  logic [FRAME_BITS-1:0] start_frame;
  logic [FRAME_BITS-1:0] end_frame;

  modport source (output valid, output event_kind, output start_frame, output end_frame,
                  input ready);
  modport sink   (input valid, input event_kind, input start_frame, input end_frame,
                  output ready);
endinterface

// ----- hw/rtl/sed_trail.sv -----
// Hysteresis trail segmenter: opens at the enter threshold, closes below exit.
module sed_trail #(
  parameter int SPEED_BITS = sed_pkg::SED_SPEED_BITS,
  parameter int FRAME_BITS = sed_pkg::SED_FRAME_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             acc,
  input  logic [SPEED_BITS-1:0]            speed,
  input  logic                             last_sample,
  input  logic [FRAME_BITS-1:0]            frame,
  input  logic [SPEED_BITS-1:0]            enter_thr,
  input  logic [SPEED_BITS-1:0]            exit_thr,
  input  logic [sed_pkg::CFG_DATA_BITS-1:0] min_len,
  output logic                             emit,
  output logic [FRAME_BITS-1:0]            emit_start,
  output logic [FRAME_BITS-1:0]            emit_end
);
  import sed_pkg::*;

  localparam int CW = (FRAME_BITS > CFG_DATA_BITS) ? FRAME_BITS : CFG_DATA_BITS;

  logic                  in_trail_r, in_trail_nxt;
  logic [FRAME_BITS-1:0] start_r, start_nxt;
  logic                  close;
  logic [FRAME_BITS-1:0] len;

  always_comb begin
    in_trail_nxt = in_trail_r;
    start_nxt    = start_r;
    close        = 1'b0;
    if (!in_trail_r && speed >= enter_thr) begin
      in_trail_nxt = 1'b1;
      start_nxt    = frame;
    end else if (in_trail_r && speed < exit_thr) begin
      close        = 1'b1;
      in_trail_nxt = 1'b0;
    end
    // close any open trail at the clip's last frame
    if (last_sample && in_trail_nxt) begin
      close        = 1'b1;
      in_trail_nxt = 1'b0;
    end
  end

  assign len        = frame - start_nxt;
  assign emit       = close && (CW'(len) >= CW'(min_len));
  assign emit_start = start_nxt;
  assign emit_end   = frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_trail_r <= 1'b0;
    end else if (acc) begin
      in_trail_r <= in_trail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      start_r <= start_nxt;
    end
  end

endmodule

// ----- hw/rtl/sed_impact.sv -----
// Impact finder: lookahead window, largest speed drop, clamped offset frame.
module sed_impact #(
  parameter int SPEED_BITS = sed_pkg::SED_SPEED_BITS,
  parameter int FRAME_BITS = sed_pkg::SED_FRAME_BITS,
  parameter int LOOKAHEAD  = sed_pkg::SED_LOOKAHEAD
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    acc,
  input  logic [SPEED_BITS-1:0]                   speed,
  input  logic                                    last_sample,
  input  logic [FRAME_BITS-1:0]                   frame,
  input  logic [SPEED_BITS-1:0]                   enter_thr,
  input  logic signed [sed_pkg::CFG_DATA_BITS-1:0] offset,
  output logic                                    hit,
  output logic [FRAME_BITS-1:0]                   hit_frame
);
  import sed_pkg::*;

  localparam int OW = ((FRAME_BITS > CFG_DATA_BITS) ? FRAME_BITS : CFG_DATA_BITS) + 2;

  logic [SPEED_BITS-1:0] win_r [LOOKAHEAD];
  logic [SPEED_BITS-1:0] best_drop_r, best_drop_nxt;
  logic [FRAME_BITS-1:0] best_frame_r, best_frame_nxt;
  logic                  best_valid_r, best_valid_nxt;

  logic [SPEED_BITS-1:0] w    [LOOKAHEAD+1];
  logic [SPEED_BITS-1:0] smin [LOOKAHEAD+1];
  logic [SPEED_BITS-1:0] drop [LOOKAHEAD+1];
  logic                  qual [LOOKAHEAD+1];
  logic signed [OW-1:0]  sum;
  logic signed [OW-1:0]  frame_s;

  always_comb begin
    for (int i = 0; i < LOOKAHEAD; i++) begin
      w[i] = win_r[i];
    end
    w[LOOKAHEAD] = speed;
    // minimum of each slot and all newer slots
    smin[LOOKAHEAD] = w[LOOKAHEAD];
    for (int i = LOOKAHEAD - 1; i >= 0; i--) begin
      smin[i] = (w[i] < smin[i+1]) ? w[i] : smin[i+1];
    end
    for (int i = 0; i <= LOOKAHEAD; i++) begin
      drop[i] = w[i] - smin[i];
      // slot i holds frame (frame - LOOKAHEAD + i); frame zero never counts
      qual[i] = (i == 0 || last_sample) && (frame >= FRAME_BITS'(LOOKAHEAD - i + 1))
                && (w[i] >= enter_thr);
    end
  end

  always_comb begin
    best_drop_nxt  = best_drop_r;
    best_frame_nxt = best_frame_r;
    best_valid_nxt = best_valid_r;
    for (int i = 0; i <= LOOKAHEAD; i++) begin
      if (qual[i] && drop[i] > best_drop_nxt) begin
        best_drop_nxt  = drop[i];
        best_frame_nxt = frame - FRAME_BITS'(LOOKAHEAD - i);
        best_valid_nxt = 1'b1;
      end
    end
  end

  // Add the signed offset and clamp to [0, frame]
  always_comb begin
    sum     = $signed({{(OW-FRAME_BITS){1'b0}}, best_frame_nxt})
              + $signed({{(OW-CFG_DATA_BITS){offset[CFG_DATA_BITS-1]}}, offset});
    frame_s = $signed({{(OW-FRAME_BITS){1'b0}}, frame});
    if (sum < 0) begin
      hit_frame = '0;
    end else if (sum > frame_s) begin
      hit_frame = frame;
    end else begin
      hit_frame = sum[FRAME_BITS-1:0];
    end
  end

  assign hit = last_sample && best_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
      best_drop_r  <= '0;
    end else if (acc) begin
      best_valid_r <= last_sample ? 1'b0 : best_valid_nxt;
      best_drop_r  <= last_sample ? '0 : best_drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      best_frame_r <= best_frame_nxt;
      for (int i = 0; i < LOOKAHEAD; i++) begin
        win_r[i] <= w[i+1];
      end
    end
  end

endmodule

// ----- hw/rtl/sed_obuf.sv -----
// Two-entry output buffer: result register plus skid entry.
module sed_obuf #(
  parameter int FRAME_BITS = sed_pkg::SED_FRAME_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic                  push_kind,
  input  logic [FRAME_BITS-1:0] push_start,
  input  logic [FRAME_BITS-1:0] push_end,
  output logic                  can_push,
  sed_out_if.source             out_ch
);
  localparam int PW = 2 * FRAME_BITS + 1;

  logic          out_valid_r;
  logic          skid_valid_r;
  logic [PW-1:0] out_data_r;
  logic [PW-1:0] skid_data_r;
  logic [PW-1:0] push_data;
  logic          pop;
  logic          load_out;

  assign push_data = {push_kind, push_start, push_end};
  assign pop       = out_valid_r && out_ch.ready;
  assign load_out  = !out_valid_r || pop;
  assign can_push  = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end
    if (!load_out && push) begin
      skid_data_r <= push_data;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_kind  = out_data_r[PW-1];
  assign out_ch.start_frame = out_data_r[2*FRAME_BITS-1:FRAME_BITS];
  assign out_ch.end_frame   = out_data_r[FRAME_BITS-1:0];

endmodule

// ----- hw/rtl/speed_event_detector_top.sv -----
// Top level of the speed event detector: config registers, frame counter, detectors.
//
// Usage: one speed sample (unsigned 12.4) per frame arrives on in_ch, with
// last_sample high on the clip's final frame. Frames are counted internally
// from zero and the count saturates at the top of the frame range.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// mode selects trail intervals or at most one impact point per clip on out_ch; both
// detectors always run, mode only picks which one reports.
// Throughput: one item per cycle while the skid entry is empty; every sample is
// handled in the cycle it is accepted, set by the single pass through the window
// min chain and scorer. Each result is registered before it is valid on out_ch.
// Stall: results go to an output register backed by one skid entry; in_ch
// stays ready while the skid entry is empty, so a stalled receiver blocks the
// input only after two results are pending.
// Reset (synchronous, active low): registers take their defaults (minimum
// trail length one, everything else zero), per-clip state clears, both
// output entries empty. Per-clip state clears again after every last frame.
module speed_event_detector_top #(
  parameter int SPEED_BITS = sed_pkg::SED_SPEED_BITS,
  parameter int FRAME_BITS = sed_pkg::SED_FRAME_BITS,
  parameter int LOOKAHEAD  = sed_pkg::SED_LOOKAHEAD
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sed_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [sed_pkg::CFG_DATA_BITS-1:0] cfg_data,
  sed_in_if.sink                            in_ch,
  sed_out_if.source                         out_ch
);
  import sed_pkg::*;

  localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;

  // Configuration registers
  mode_t                     mode_r;
  logic [CFG_DATA_BITS-1:0]  enter_r;
  logic [CFG_DATA_BITS-1:0]  exit_r;
  logic [CFG_DATA_BITS-1:0]  min_len_r;
  logic [CFG_DATA_BITS-1:0]  offset_r;

  logic [FRAME_BITS-1:0]     frame_r, frame_nxt;
  logic                      acc;
  logic                      can_push;
  logic [SPEED_BITS-1:0]     enter_eff;
  logic [SPEED_BITS-1:0]     exit_eff;

  logic                      trail_emit;
  logic [FRAME_BITS-1:0]     trail_start;
  logic [FRAME_BITS-1:0]     trail_end;
  logic                      impact_hit;
  logic [FRAME_BITS-1:0]     impact_frame;

  logic                      push;
  logic                      push_kind;
  logic [FRAME_BITS-1:0]     push_start;
  logic [FRAME_BITS-1:0]     push_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_TRAIL;
      enter_r   <= '0;
      exit_r    <= '0;
      min_len_r <= MIN_TRAIL_RST;
      offset_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:        mode_r    <= mode_t'(cfg_data[0]);
        CFG_ENTER_THR:   enter_r   <= cfg_data;
        CFG_EXIT_THR:    exit_r    <= cfg_data;
        CFG_MIN_TRAIL:   min_len_r <= cfg_data;
        CFG_IMPACT_OFFS: offset_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Thresholds compare at the sample width
  assign enter_eff = SPEED_BITS'(enter_r);
  assign exit_eff  = SPEED_BITS'(exit_r);

  assign in_ch.ready = can_push;
  assign acc         = in_ch.valid && can_push;

  // Frame counter: drop to zero after the last frame, hold at the top
  always_comb begin
    if (in_ch.last_sample) begin
      frame_nxt = '0;
    end else if (frame_r != FRAME_MAX) begin
      frame_nxt = frame_r + 1'b1;
    end else begin
      frame_nxt = frame_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
    end else if (acc) begin
      frame_r <= frame_nxt;
    end
  end

  sed_trail #(
    .SPEED_BITS (SPEED_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_trail (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .speed       (in_ch.speed),
    .last_sample (in_ch.last_sample),
    .frame       (frame_r),
    .enter_thr   (enter_eff),
    .exit_thr    (exit_eff),
    .min_len     (min_len_r),
    .emit        (trail_emit),
    .emit_start  (trail_start),
    .emit_end    (trail_end)
  );

  sed_impact #(
    .SPEED_BITS (SPEED_BITS),
    .FRAME_BITS (FRAME_BITS),
    .LOOKAHEAD  (LOOKAHEAD)
  ) u_impact (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .speed       (in_ch.speed),
    .last_sample (in_ch.last_sample),
    .frame       (frame_r),
    .enter_thr   (enter_eff),
    .offset      ($signed(offset_r)),
    .hit         (impact_hit),
    .hit_frame   (impact_frame)
  );

  // Pick the reporting detector by mode
  always_comb begin
    if (mode_r == MODE_TRAIL) begin
      push       = acc && trail_emit;
      push_kind  = EV_TRAIL;
      push_start = trail_start;
      push_end   = trail_end;
    end else begin
      push       = acc && impact_hit;
      push_kind  = EV_IMPACT;
      push_start = impact_frame;
      push_end   = impact_frame;
    end
  end

  sed_obuf #(
    .FRAME_BITS (FRAME_BITS)
  ) u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_kind  (push_kind),
    .push_start (push_start),
    .push_end   (push_end),
    .can_push   (can_push),
    .out_ch     (out_ch)
  );

`ifndef ASSERT_OFF
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with no result pending");

  a_clip_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.last_sample) |=> (frame_r == '0))
    else $error("frame count not cleared after last frame");

  a_frame_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_ch.last_sample && frame_r != FRAME_MAX) |=> (frame_r == $past(frame_r) + 1'b1))
    else $error("frame count did not advance");

  a_trail_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.event_kind == EV_TRAIL) |-> (out_ch.start_frame <= out_ch.end_frame))
    else $error("trail ends before it starts");

  a_impact_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.event_kind == EV_IMPACT) |-> (out_ch.start_frame == out_ch.end_frame))
    else $error("impact start and end differ");
`endif

endmodule
